// ===== sv/poly_pkg.sv =====
package poly_pkg;

  localparam int unsigned AccW  = 130;
  localparam int unsigned RW    = 124;
  localparam int unsigned CntW  = 7;

  // modulus 2^130 - 5
  localparam logic [AccW-1:0] Prime = 130'h3fffffffffffffffffffffffffffffffb;

  localparam logic [1:0] REG_R_LO = 2'd0;
  localparam logic [1:0] REG_R_HI = 2'd1;
  localparam logic [1:0] REG_S_LO = 2'd2;
  localparam logic [1:0] REG_S_HI = 2'd3;

  // Mask the valid bytes and place the pad bit (bit 128 for a full block)
  function automatic logic [AccW-1:0] pad_block(input logic [127:0] blk,
                                                input logic [4:0] cnt);
    logic [4:0]      nn;
    logic [AccW-1:0] v;
    nn = (cnt > 5'd16) ? 5'd16 : cnt;
    v  = '0;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < nn) v[8*i +: 8] = blk[8*i +: 8];
    end
    for (int i = 0; i < 17; i++) begin
      if (5'(i) == nn) v[8*i] = 1'b1;
    end
    return v;
  endfunction

endpackage

// ===== sv/poly_mul.sv =====
module poly_mul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [poly_pkg::AccW-1:0] op_a,
  input  logic [poly_pkg::RW-1:0]   op_r,
  output logic                      done,
  output logic [poly_pkg::AccW-1:0] prod
);
  import poly_pkg::*;

  logic [AccW-1:0] acc_r, acc_nxt, a_r;
  logic [RW-1:0]   r_r;
  logic [CntW-1:0] cnt_r;
  logic            busy_r;
  logic [AccW+1:0] x, p1, p2;

  // double, add the multiplicand on a set key bit, fold back below the prime
  always_comb begin
    p1 = {2'b00, Prime};
    p2 = {1'b0, Prime, 1'b0};
    x  = {1'b0, acc_r, 1'b0} + (r_r[RW-1] ? {2'b00, a_r} : '0);
    if (x >= p2)      acc_nxt = AccW'(x - p2);
    else if (x >= p1) acc_nxt = AccW'(x - p1);
    else              acc_nxt = AccW'(x);
  end

  // shift the key through one bit a cycle, most significant first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        acc_r  <= '0;
        a_r    <= op_a;
        r_r    <= op_r;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        r_r   <= {r_r[RW-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(RW - 1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign prod = acc_r;

endmodule

// ===== sv/poly1305_mac.sv =====
// Channel  | Direction | Word
// in_      | slave     | tdata: block_low, block_high, byte_count; tlast: last_block
// out_     | master    | tdata: tag_low, tag_high; tuser: error
// cfg_     | slave     | cfg_index selects key register, cfg_data its value
// A block passes through one add, 124 bit steps of the serial multiplier and a hand-over.
// A last item adds the tag state ST_FIN; an error word goes from acceptance through ST_ADD
// and ST_FIN back to ST_IDLE, an empty word that is not last through ST_ADD alone.
// Reset (synchronous, rst_n low) clears the accumulator, keys and output valid.
// A waiting result does not block input; the block stalls only when a second
// result is due while the first is still held.
module poly1305_mac (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // block_low, block_high, byte_count, zero fill
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // tag_low, tag_high
  output logic         out_tuser,  // error
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  import poly_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ADD  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t          state_r;
  logic [63:0]     r_lo_r, r_hi_r, s_lo_r, s_hi_r;
  logic [127:0]    blk_r;
  logic [4:0]      cnt_r;
  logic            last_r, err_r;
  logic [AccW-1:0] h_r;
  logic [AccW:0]   sum;
  logic [AccW-1:0] sum_red;
  logic [RW-1:0]   r_clamp;
  logic            mul_start, mul_done;
  logic [AccW-1:0] mul_prod;
  logic            short_blk;
  logic [127:0]    tag;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);

  assign r_clamp = RW'({r_hi_r & 64'h0ffffffc0ffffffc, r_lo_r & 64'h0ffffffc0fffffff});
  assign short_blk = (cnt_r != 5'd0) && (cnt_r < 5'd16);

  // add the padded block, then one subtract brings it under the prime
  always_comb begin
    sum     = {1'b0, h_r} + {1'b0, pad_block(blk_r, cnt_r)};
    sum_red = (sum >= {1'b0, Prime}) ? AccW'(sum - {1'b0, Prime}) : AccW'(sum);
  end

  assign tag       = h_r[127:0] + {s_hi_r, s_lo_r};
  assign mul_start = (state_r == ST_ADD) && !(short_blk && !last_r) && (cnt_r != 5'd0);

  poly_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (sum_red),
    .op_r  (r_clamp),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_lo_r <= '0;
      r_hi_r <= '0;
      s_lo_r <= '0;
      s_hi_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_R_LO: r_lo_r <= cfg_data;
        REG_R_HI: r_hi_r <= cfg_data;
        REG_S_LO: s_lo_r <= cfg_data;
        REG_S_HI: s_hi_r <= cfg_data;
        default:  ;
      endcase
    end
  end

  // sequence one word: add, multiply unless empty or in error, then hand out the tag or error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      h_r        <= '0;
      out_tvalid <= 1'b0;
      err_r      <= 1'b0;
    end else begin
      if (out_tvalid && out_tready && (state_r != ST_FIN)) out_tvalid <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            blk_r   <= in_tdata[127:0];
            cnt_r   <= in_tdata[132:128];
            last_r  <= in_tlast;
            state_r <= ST_ADD;
          end
        end
        ST_ADD: begin
          err_r <= short_blk && !last_r;
          if (short_blk && !last_r) state_r <= ST_FIN;
          else if (cnt_r != 5'd0)   state_r <= ST_MUL;
          else if (last_r)          state_r <= ST_FIN;
          else                      state_r <= ST_IDLE;
        end
        ST_MUL: begin
          if (mul_done) begin
            h_r     <= mul_prod;
            state_r <= last_r ? ST_FIN : ST_IDLE;
          end
        end
        ST_FIN: begin
          if (!out_tvalid || out_tready) begin
            out_tvalid <= 1'b1;
            out_tuser  <= err_r;
            out_tdata  <= err_r ? '0 : tag;
            if (!err_r) h_r <= '0;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
